[rtl/keyword_query_classifier_macros.svh]
// Assertion macros for the keyword query classifier
`ifndef KEYWORD_QUERY_CLASSIFIER_MACROS_SVH
`define KEYWORD_QUERY_CLASSIFIER_MACROS_SVH
`ifndef SYNTHESIS
`define KQC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define KQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KQC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KQC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/kqc_pkg.sv]
// ----------------------------------------------------------------------------
// kqc_pkg
// Keyword ROMs, class codes and helpers for the keyword query classifier.
// ----------------------------------------------------------------------------
package kqc_pkg;

  localparam int WINDOW_LEN_DEF    = 19;
  localparam int SIMPLE_COUNT_DEF  = 19;
  localparam int COMPLEX_COUNT_DEF = 18;
  localparam int SIMPLE_ROM_SIZE   = 19;
  localparam int COMPLEX_ROM_SIZE  = 18;
  localparam int KW_MAX            = 19;

  localparam logic [1:0] CLASS_SIMPLE  = 2'd0;
  localparam logic [1:0] CLASS_MEDIUM  = 2'd1;
  localparam logic [1:0] CLASS_COMPLEX = 2'd2;

  // keyword text, first character in the top byte, left aligned
  typedef logic [KW_MAX*8-1:0] kw_text_t;

  typedef struct packed {
    logic [7:0] len;
    kw_text_t   text;
  } kw_t;

  function automatic kw_t mk(input logic [7:0] len, input kw_text_t s);
    kw_t k;
    k.len  = len;
    k.text = s << (8 * (KW_MAX - int'(len)));
    return k;
  endfunction

  function automatic kw_t simple_kw(input int idx);
    kw_t k;
    case (idx)
      0:  k = mk(8'd7,  "explain");
      1:  k = mk(8'd7,  "what is");
      2:  k = mk(8'd9,  "what does");
      3:  k = mk(8'd8,  "what are");
      4:  k = mk(8'd8,  "how does");
      5:  k = mk(8'd8,  "describe");
      6:  k = mk(8'd7,  "show me");
      7:  k = mk(8'd4,  "find");
      8:  k = mk(8'd8,  "where is");
      9:  k = mk(8'd4,  "list");
      10: k = mk(8'd7,  "tell me");
      11: k = mk(8'd6,  "define");
      12: k = mk(8'd10, "meaning of");
      13: k = mk(8'd18, "help me understand");
      14: k = mk(8'd5,  "print");
      15: k = mk(8'd7,  "display");
      16: k = mk(8'd4,  "read");
      17: k = mk(8'd3,  "get");
      18: k = mk(8'd7,  "look up");
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic kw_t complex_kw(input int idx);
    kw_t k;
    case (idx)
      0:  k = mk(8'd9,  "architect");
      1:  k = mk(8'd6,  "design");
      2:  k = mk(8'd15, "refactor entire");
      3:  k = mk(8'd7,  "rewrite");
      4:  k = mk(8'd11, "restructure");
      5:  k = mk(8'd16, "implement system");
      6:  k = mk(8'd7,  "build a");
      7:  k = mk(8'd19, "create a new system");
      8:  k = mk(8'd17, "add a new feature");
      9:  k = mk(8'd16, "across all files");
      10: k = mk(8'd10, "every file");
      11: k = mk(8'd9,  "all files");
      12: k = mk(8'd14, "multiple files");
      13: k = mk(8'd10, "multi-file");
      14: k = mk(8'd13, "codebase-wide");
      15: k = mk(8'd9,  "migration");
      16: k = mk(8'd8,  "overhaul");
      17: k = mk(8'd8,  "redesign");
      default: k = '0;
    endcase
    return k;
  endfunction

  // character of a keyword that must sit at window age pos (0 newest)
  function automatic logic [7:0] kw_char(input kw_t k, input int pos);
    logic [7:0] c;
    c = 8'd0;
    if (pos < int'(k.len))
      c = k.text[8*(KW_MAX-int'(k.len)+pos) +: 8];
    return c;
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

endpackage

[rtl/kqc_cell.sv]
// ----------------------------------------------------------------------------
// kqc_cell
// One window slot: holds a byte aged by its place, hands it on each item.
// ----------------------------------------------------------------------------
module kqc_cell (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       clr,
  input  logic [7:0] byte_in,
  output logic [7:0] byte_out
);

  logic [7:0] byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && clr)) begin
      byte_r <= 8'd0;
    end else if (adv) begin
      byte_r <= byte_in;
    end
  end

  assign byte_out = byte_r;

endmodule

[rtl/kqc_match.sv]
// ----------------------------------------------------------------------------
// kqc_match
// Parallel comparators: does any keyword of a list end at the newest byte.
// ----------------------------------------------------------------------------
module kqc_match #(
  parameter int WINDOW_LEN = kqc_pkg::WINDOW_LEN_DEF,
  parameter int COUNT      = 1,
  parameter bit IS_COMPLEX = 1'b0
) (
  input  logic [WINDOW_LEN*8-1:0] win,
  output logic                    hit
);

  localparam int ROM_N = IS_COMPLEX ? kqc_pkg::COMPLEX_ROM_SIZE : kqc_pkg::SIMPLE_ROM_SIZE;
  localparam int N     = COUNT < ROM_N ? COUNT : ROM_N;

  logic [N-1:0] hits;

  for (genvar k = 0; k < N; k++) begin : g_kw
    localparam kqc_pkg::kw_t KW = IS_COMPLEX ? kqc_pkg::complex_kw(k) : kqc_pkg::simple_kw(k);
    always_comb begin
      hits[k] = (int'(KW.len) <= WINDOW_LEN);
      for (int p = 0; p < WINDOW_LEN; p++) begin
        if (p < int'(KW.len) && win[8*p +: 8] != kqc_pkg::kw_char(KW, p))
          hits[k] = 1'b0;
      end
    end
  end

  assign hit = |hits;

endmodule

[rtl/keyword_query_classifier.sv]
// ----------------------------------------------------------------------------
// keyword_query_classifier
// Classifies a byte-stream query as simple, medium or complex by keywords.
// ----------------------------------------------------------------------------
// channel | dir | tdata                 | tlast
// in_     | in  | [7:0] text_byte       | end_of_query
// out_    | out | [1:0] query_class     | always 1
// One byte accepted per cycle unless stalled; the window is a chain of byte cells.
// A result appears in the cycle after the final byte is accepted, in an output register.
// Input is stalled only while a result waits and the sink is not ready.
// Reset clears window, sticky flags and the output valid.
// ----------------------------------------------------------------------------
`include "keyword_query_classifier_macros.svh"

module keyword_query_classifier #(
  parameter int WINDOW_LEN    = kqc_pkg::WINDOW_LEN_DEF,
  parameter int SIMPLE_COUNT  = kqc_pkg::SIMPLE_COUNT_DEF,
  parameter int COMPLEX_COUNT = kqc_pkg::COMPLEX_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [1:0] query_class, zero filled
  output logic       out_tlast
);

  localparam int HIST = WINDOW_LEN - 1;

  logic [WINDOW_LEN*8-1:0] win;
  logic adv, chit, shit;
  logic complex_r, simple_r, complex_nxt, simple_nxt;
  logic out_valid_r;
  logic [1:0] class_r, class_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign adv       = in_tvalid && in_tready;

  assign win[7:0] = kqc_pkg::fold(in_tdata);

  for (genvar i = 0; i < HIST; i++) begin : g_cell
    kqc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .clr     (in_tlast),
      .byte_in (win[8*i +: 8]),
      .byte_out(win[8*(i+1) +: 8])
    );
  end

  kqc_match #(.WINDOW_LEN(WINDOW_LEN), .COUNT(COMPLEX_COUNT), .IS_COMPLEX(1'b1))
    u_cmatch (.win(win), .hit(chit));
  kqc_match #(.WINDOW_LEN(WINDOW_LEN), .COUNT(SIMPLE_COUNT), .IS_COMPLEX(1'b0))
    u_smatch (.win(win), .hit(shit));

  always_comb begin
    complex_nxt = complex_r || chit;
    simple_nxt  = simple_r || shit;
    if (complex_nxt)
      class_nxt = kqc_pkg::CLASS_COMPLEX;
    else if (simple_nxt)
      class_nxt = kqc_pkg::CLASS_SIMPLE;
    else
      class_nxt = kqc_pkg::CLASS_MEDIUM;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      complex_r   <= 1'b0;
      simple_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready)
        out_valid_r <= 1'b0;
      if (adv) begin
        complex_r <= in_tlast ? 1'b0 : complex_nxt;
        simple_r  <= in_tlast ? 1'b0 : simple_nxt;
        if (in_tlast)
          out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_tlast)
      class_r <= class_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, class_r};
  assign out_tlast  = 1'b1;

  `KQC_ASSERT_NEXT(a_res_after_last, clk, rst_n, adv && in_tlast, out_tvalid)
  `KQC_ASSERT_NEXT(a_flags_clear, clk, rst_n, adv && in_tlast, !complex_r && !simple_r)
  `KQC_ASSERT_IMPL(a_class_legal, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'd3)
  `KQC_ASSERT_IMPL(a_no_stall_empty, clk, rst_n, !out_tvalid, in_tready)

endmodule
